// ===== src/urc_pkg.sv =====
// urc_pkg: shared types, constants and the checksum helper of the udp receive checker
// used by urc_front, urc_queue, urc_back and udp_receive_checker_top
// depends on nothing
package urc_pkg;

   // header geometry
   localparam logic [5:0]  MIN_IP_HEADER = 6'd20;
   localparam logic [15:0] UDP_HEADER    = 16'd8;
   localparam logic [15:0] POS_MAX       = 16'hFFFF;
   localparam logic [15:0] SUM_GOOD      = 16'hFFFF;

   // fixed ip header byte positions
   localparam logic [15:0] POS_VER_IHL   = 16'd0;
   localparam logic [15:0] POS_LEN_HI    = 16'd2;
   localparam logic [15:0] POS_LEN_LO    = 16'd3;
   localparam logic [15:0] POS_PROTOCOL  = 16'd9;
   localparam logic [15:0] POS_ADDR_LO   = 16'd12;
   localparam logic [15:0] POS_ADDR_HI   = 16'd19;

   // udp header byte offsets
   localparam logic [15:0] OFF_ULEN_HI   = 16'd4;
   localparam logic [15:0] OFF_ULEN_LO   = 16'd5;
   localparam logic [15:0] OFF_CKS_HI    = 16'd6;
   localparam logic [15:0] OFF_CKS_LO    = 16'd7;

   // summary queue geometry
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // statistic counter slots
   localparam int CNT_SEEN      = 0;
   localparam int CNT_SHORT     = 1;
   localparam int CNT_LENGTH    = 2;
   localparam int CNT_CHECKSUM  = 3;
   localparam int CNT_BROADCAST = 4;
   localparam int NUM_COUNTERS  = 5;

   // result width: outcome plus five 32-bit counters, padded to whole bytes
   localparam int RSP_BITS      = 3 + 5 * 32;
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      OUTCOME_SHORT          = 3'd0,
      OUTCOME_BAD_LENGTH     = 3'd1,
      OUTCOME_BAD_CHECKSUM   = 3'd2,
      OUTCOME_BROADCAST      = 3'd3,
      OUTCOME_PORT_UNREACH   = 3'd4
   } outcome_type;

   // what the parser hands over at the end of a packet
   typedef struct packed {
      logic [15:0] sum;
      logic [7:0]  pad_hi;
      logic        pad_odd;
      logic        too_short;
      logic        len_bad;
      logic        cks_present;
      logic        bcast;
   } summary_type;

   // ones-complement add of one 16-bit word, folded back to 16 bits
   function automatic logic [15:0] add_word(input logic [15:0] s, input logic [15:0] w);
      logic [16:0] a;
      a = {1'b0, s} + {1'b0, w};
      return a[15:0] + {15'b0, a[16]};
   endfunction

endpackage

// ===== src/urc_front.sv =====
// urc_front: byte parser of the udp receive checker, one packet byte per cycle in which byte_fire is high
// tracks header fields and the running checksum, emits a summary per packet
// depends on urc_pkg
module urc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_fire,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic                 link_broadcast,
   output logic                 push_valid,
   output urc_pkg::summary_type push_data
);

   logic [15:0] pos_ff, pos_in;
   logic [5:0]  hdr_ff, hdr_in;
   logic [15:0] total_ff, total_in;
   logic [15:0] udp_ff, udp_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pending_ff, pending_in;
   logic        cks_ff, cks_in;

   logic        active;
   logic        in_udp;
   logic [15:0] off;
   logic        udp_summed;
   logic [5:0]  hdr_raw;
   logic [15:0] sum_a;
   logic [15:0] hdr_wide;
   logic [15:0] rcv;
   logic [15:0] lim;
   logic [15:0] payload;

   // per-byte header parsing and checksum accumulation
   always_comb begin
      active     = (pos_ff != urc_pkg::POS_MAX);
      pos_in     = active ? pos_ff + 16'd1 : pos_ff;
      hdr_raw    = {data_byte[3:0], 2'b00};
      hdr_in     = hdr_ff;
      total_in   = total_ff;
      udp_in     = udp_ff;
      cks_in     = cks_ff;
      pending_in = pending_ff;
      sum_a      = sum_ff;
      sum_in     = sum_ff;
      in_udp     = active && (pos_ff >= {10'b0, hdr_ff});
      off        = pos_ff - {10'b0, hdr_ff};
      udp_summed = in_udp && ((off < urc_pkg::UDP_HEADER) || (off < udp_ff));

      if (active && pos_ff == urc_pkg::POS_VER_IHL) begin
         hdr_in = (hdr_raw < urc_pkg::MIN_IP_HEADER) ? urc_pkg::MIN_IP_HEADER : hdr_raw;
      end
      if (active && pos_ff == urc_pkg::POS_LEN_HI) begin
         total_in = {data_byte, 8'h00};
      end
      if (active && pos_ff == urc_pkg::POS_LEN_LO) begin
         total_in = {total_ff[15:8], data_byte};
      end

      // protocol byte joins the pseudo-header
      if (active && pos_ff == urc_pkg::POS_PROTOCOL) begin
         sum_a = urc_pkg::add_word(sum_ff, {8'h00, data_byte});
      end

      // source and destination addresses, in 16-bit words
      if (active && (pos_ff inside {[urc_pkg::POS_ADDR_LO:urc_pkg::POS_ADDR_HI]})) begin
         if (!pos_ff[0]) begin
            pending_in = data_byte;
         end else begin
            sum_a = urc_pkg::add_word(sum_ff, {pending_ff, data_byte});
         end
      end

      // udp header fields
      if (in_udp && off == urc_pkg::OFF_ULEN_HI) begin
         udp_in = {data_byte, 8'h00};
      end
      if (in_udp && off == urc_pkg::OFF_ULEN_LO) begin
         udp_in = {udp_ff[15:8], data_byte};
      end
      if (in_udp && off == urc_pkg::OFF_CKS_HI) begin
         cks_in = (data_byte != 8'h00);
      end
      if (in_udp && off == urc_pkg::OFF_CKS_LO) begin
         cks_in = cks_ff || (data_byte != 8'h00);
      end

      // udp segment words up to the udp length
      if (udp_summed) begin
         if (!off[0]) begin
            pending_in = data_byte;
         end else begin
            sum_a = urc_pkg::add_word(sum_ff, {pending_ff, data_byte});
         end
      end

      // udp length counts twice: once in the segment, once in the pseudo-header
      sum_in = sum_a;
      if (in_udp && off == urc_pkg::OFF_ULEN_LO) begin
         sum_in = urc_pkg::add_word(sum_a, udp_in);
      end
   end

   // end-of-packet checks on the updated fields
   always_comb begin
      hdr_wide = {10'b0, hdr_in};
      rcv      = pos_in - hdr_wide;
      lim      = (udp_in < urc_pkg::UDP_HEADER) ? urc_pkg::UDP_HEADER : udp_in;
      payload  = (total_in >= hdr_wide) ? total_in - hdr_wide : 16'd0;

      push_valid            = byte_fire && last_byte;
      push_data.sum         = sum_in;
      push_data.pad_hi      = pending_in;
      push_data.pad_odd     = (pos_in > hdr_wide) && ((rcv < lim) ? rcv[0] : lim[0]);
      push_data.too_short   = ({1'b0, pos_in} < ({1'b0, hdr_wide} + 17'd8));
      push_data.len_bad     = (udp_in > payload) || (udp_in < urc_pkg::UDP_HEADER);
      push_data.cks_present = cks_in;
      push_data.bcast       = link_broadcast;
   end

   // packet state, cleared after every last byte
   always_ff @(posedge clock) begin
      if (reset || (byte_fire && last_byte)) begin
         pos_ff     <= '0;
         hdr_ff     <= '0;
         total_ff   <= '0;
         udp_ff     <= '0;
         sum_ff     <= '0;
         pending_ff <= '0;
         cks_ff     <= 1'b0;
      end else if (byte_fire) begin
         pos_ff     <= pos_in;
         hdr_ff     <= hdr_in;
         total_ff   <= total_in;
         udp_ff     <= udp_in;
         sum_ff     <= sum_in;
         pending_ff <= pending_in;
         cks_ff     <= cks_in;
      end
   end

endmodule

// ===== src/urc_queue.sv =====
// urc_queue: short queue of packet summaries between parser and result stage
// depends on urc_pkg
module urc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  urc_pkg::summary_type push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output urc_pkg::summary_type pop_data
);

   localparam logic [urc_pkg::QUEUE_PTR_BITS-1:0] PTR_LAST =
      urc_pkg::QUEUE_PTR_BITS'(urc_pkg::QUEUE_DEPTH - 1);
   localparam logic [urc_pkg::QUEUE_COUNT_BITS-1:0] COUNT_FULL =
      urc_pkg::QUEUE_COUNT_BITS'(urc_pkg::QUEUE_DEPTH);

   urc_pkg::summary_type                  entries_ff [urc_pkg::QUEUE_DEPTH];
   logic [urc_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [urc_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [urc_pkg::QUEUE_COUNT_BITS-1:0]  count_ff, count_in;
   logic                                  do_push;
   logic                                  do_pop;

   // pointer and fill bookkeeping
   always_comb begin
      push_ready = (count_ff != COUNT_FULL);
      pop_valid  = (count_ff != '0);
      pop_data   = entries_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/urc_back.sv =====
// urc_back: classifies each packet summary, updates saturating statistics
// and holds the result transaction until it is taken; depends on urc_pkg
module urc_back #(
   parameter int COUNTER_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  urc_pkg::summary_type               pop_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [urc_pkg::RSP_DATA_BITS-1:0]  rsp_data
);

   localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;

   logic [COUNTER_BITS-1:0]             count_ff [urc_pkg::NUM_COUNTERS];
   logic [COUNTER_BITS-1:0]             count_in [urc_pkg::NUM_COUNTERS];
   logic [31:0]                         count_low [urc_pkg::NUM_COUNTERS];
   logic [urc_pkg::NUM_COUNTERS-1:0]    bump;
   logic [15:0]                         sum_final;
   urc_pkg::outcome_type                outcome;
   logic                                rsp_valid_ff;
   logic [urc_pkg::RSP_DATA_BITS-1:0]   rsp_data_ff;
   logic                                take;

   // odd-length padding and outcome priority
   always_comb begin
      sum_final = pop_data.pad_odd ?
                  urc_pkg::add_word(pop_data.sum, {pop_data.pad_hi, 8'h00}) : pop_data.sum;
      if (pop_data.too_short) begin
         outcome = urc_pkg::OUTCOME_SHORT;
      end else if (pop_data.len_bad) begin
         outcome = urc_pkg::OUTCOME_BAD_LENGTH;
      end else if (pop_data.cks_present && sum_final != urc_pkg::SUM_GOOD) begin
         outcome = urc_pkg::OUTCOME_BAD_CHECKSUM;
      end else if (pop_data.bcast) begin
         outcome = urc_pkg::OUTCOME_BROADCAST;
      end else begin
         outcome = urc_pkg::OUTCOME_PORT_UNREACH;
      end
   end

   // which counters this packet bumps
   always_comb begin
      bump = '0;
      bump[urc_pkg::CNT_SEEN] = 1'b1;
      case (outcome)
         urc_pkg::OUTCOME_SHORT:        bump[urc_pkg::CNT_SHORT]     = 1'b1;
         urc_pkg::OUTCOME_BAD_LENGTH:   bump[urc_pkg::CNT_LENGTH]    = 1'b1;
         urc_pkg::OUTCOME_BAD_CHECKSUM: bump[urc_pkg::CNT_CHECKSUM]  = 1'b1;
         urc_pkg::OUTCOME_BROADCAST:    bump[urc_pkg::CNT_BROADCAST] = 1'b1;
         default: ;
      endcase
   end

   // saturating increments and the low 32 bits shown on the result
   for (genvar i = 0; i < urc_pkg::NUM_COUNTERS; i++) begin : g_count
      assign count_in[i] = (bump[i] && count_ff[i] != COUNT_MAX) ?
                           count_ff[i] + COUNTER_BITS'(1) : count_ff[i];
      if (COUNTER_BITS >= 32) begin : g_wide
         assign count_low[i] = count_in[i][31:0];
      end else begin : g_narrow
         assign count_low[i] = {{(32 - COUNTER_BITS){1'b0}}, count_in[i]};
      end
   end

   // a summary is taken when the output register is free or being emptied
   assign take      = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < urc_pkg::NUM_COUNTERS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (take) begin
            rsp_valid_ff <= 1'b1;
            for (int i = 0; i < urc_pkg::NUM_COUNTERS; i++) begin
               count_ff[i] <= count_in[i];
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= {{(urc_pkg::RSP_DATA_BITS - urc_pkg::RSP_BITS){1'b0}},
                         count_low[urc_pkg::CNT_BROADCAST],
                         count_low[urc_pkg::CNT_CHECKSUM],
                         count_low[urc_pkg::CNT_LENGTH],
                         count_low[urc_pkg::CNT_SHORT],
                         count_low[urc_pkg::CNT_SEEN],
                         outcome};
      end
   end

endmodule

// ===== src/udp_receive_checker_top.sv =====
// Receive-side UDP checker. Takes an IPv4 packet one byte per cycle from the IP header on,
// with tlast on the final byte, and gives one result transaction per packet: the outcome
// (too short, bad length, bad checksum, broadcast drop, port unreachable) and the five
// saturating statistic counters after this packet. Bytes are taken every cycle: the parser
// has no stall of its own, and its only limit is the four-entry summary queue in front of
// the result register, so req_tready drops only when five packet results wait unread (four
// in the queue behind the one held in the result register).
// After the last byte its summary is written into the queue and then, when the output is free,
// into the result register. Checksum bytes are summed in 16-bit words as they arrive.
// depends on urc_pkg, urc_front, urc_queue, urc_back
module udp_receive_checker_top #(
   parameter int COUNTER_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   input  logic [0:0]   req_tuser,   // [0] link_broadcast
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [2:0] outcome, [34:3] packets_seen, [66:35] short_drops, [98:67] length_drops,
   // [130:99] checksum_drops, [162:131] broadcast_drops, [167:163] zero
   output logic [urc_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   urc_pkg::summary_type push_data;
   urc_pkg::summary_type pop_data;
   logic                 push_valid;
   logic                 push_ready;
   logic                 pop_valid;
   logic                 pop_ready;
   logic                 byte_fire;

   // a byte is taken whenever the summary queue has room
   assign req_tready = push_ready;
   assign byte_fire  = req_tvalid && req_tready;

   urc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .byte_fire      (byte_fire),
      .data_byte      (req_tdata),
      .last_byte      (req_tlast),
      .link_broadcast (req_tuser[0]),
      .push_valid     (push_valid),
      .push_data      (push_data)
   );

   urc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   urc_back #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule
